/* sv/smpid_pkg.sv */
// Shared types and constants for the Smith predictor PID step block.
// No dependencies; imported by smith_predictor_pid_step_top.
package smpid_pkg;

    // Input item: one control sample
    typedef struct packed {
        logic [11:0] measured_temp;
        logic [9:0]  setpoint;
    } in_item_t;

    // Result item: heater duty and predicted temperature
    typedef struct packed {
        logic [9:0]         duty;
        logic signed [31:0] predicted_temp;
    } out_item_t;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_NOW   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_PREV  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_PREV2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MODEL_NUM0 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MODEL_NUM1 = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_MODEL_DEN1 = 3'd5;

    // Configuration reset values
    localparam logic signed [31:0] RST_GAIN_NOW   = 32'sd111732;
    localparam logic signed [31:0] RST_GAIN_PREV  = -32'sd107157;
    localparam logic signed [31:0] RST_GAIN_PREV2 = 32'sd0;
    localparam logic signed [31:0] RST_MODEL_NUM0 = 32'sd0;
    localparam logic signed [31:0] RST_MODEL_NUM1 = 32'sd4116;
    localparam logic signed [31:0] RST_MODEL_DEN1 = -32'sd63786;

    // Upper clamp of the control output, whole degrees
    localparam int CLAMP_DEGREES = 1000;

    // Sequencer steps; each multiply step names the multiply issued in that step (STEP_ERR and STEP_LAST issue none)
    localparam int unsigned STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_D_NEW   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_D_OLD   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_D_FB    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_F_NEW   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_F_OLD   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_F_FB    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_P_PREV  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_P_PREV2 = 4'd7;
    localparam logic [STEP_W-1:0] STEP_ERR     = 4'd8;
    localparam logic [STEP_W-1:0] STEP_P_NOW   = 4'd9;
    localparam logic [STEP_W-1:0] STEP_LAST    = 4'd10;

endpackage

/* sv/smith_predictor_pid_step_top.sv */
// Smith predictor with incremental PID, one control sample per transfer.
// Depends on smpid_pkg (item types, register indexes, sequencer steps).
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one sample: measured
//   temperature in quarter degrees and setpoint in whole degrees. in_stall is
//   high while an item is in work.
//   Output channel (out_valid / out_stall / out_data) gives one result per
//   sample: duty and the Q-format predicted temperature. The result sits in
//   an output register and holds while out_stall is high.
//   Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data)
//   writes the six gain and model coefficients; cfg_ready is always high.
//   Write only while no item is in work. Indexes beyond the list are ignored.
// Timing:
//   The first sample after reset only loads the plant models and gives a
//   result of zero duty and zero prediction. Every later sample runs the
//   sequencer steps: nine multiplies are issued in turn into one shared 32x32
//   multiplier with a registered product, and the accumulate, prediction and
//   error steps are folded around it. The next sample is taken in the cycle
//   after the result is loaded, so no sample is taken while one is in work.
//   If the previous result is still stalled when a new one is ready, the
//   sequencer holds its last step until the output register frees.
// Reset: rst_n (asynchronous, active low) clears the models, history, errors
//   and the start flag, and restores the coefficient defaults.
module smith_predictor_pid_step_top #(
    parameter int DELAY     = 2,
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  smpid_pkg::in_item_t        in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output smpid_pkg::out_item_t       out_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [smpid_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                cfg_data
);
    import smpid_pkg::*;

    localparam int HIST_DEPTH = DELAY + 1;
    localparam int ACC_W      = 35;
    localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [63:0] TOP_WIDE = 64'(CLAMP_DEGREES) <<< FRAC_BITS;
    localparam logic signed [31:0] TOP_U    =
        (TOP_WIDE > 64'sd2147483647) ? 32'sh7FFFFFFF : TOP_WIDE[31:0];

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_PRIME = 3'b010,
        ST_RUN   = 3'b100
    } state_t;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Round a full product to nearest (half up) and saturate
    function automatic logic signed [31:0] round_prod(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = (p + HALF_LSB) >>> FRAC_BITS;
        return sat32(s);
    endfunction

    // Control state
    state_t            state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              started_reg, started_next;
    logic              out_valid_reg, out_valid_next;

    // Coefficient registers
    logic signed [31:0] gain_now_reg, gain_prev_reg, gain_prev2_reg;
    logic signed [31:0] model_num0_reg, model_num1_reg, model_den1_reg;

    // Controller state
    logic signed [31:0] hist_reg [HIST_DEPTH];
    logic signed [31:0] hist_next [HIST_DEPTH];
    logic signed [31:0] err_last_reg, err_last_next;
    logic signed [31:0] err_before_reg, err_before_next;
    logic signed [31:0] dprev_reg, dprev_next;
    logic signed [31:0] fprev_reg, fprev_next;

    // Work registers
    in_item_t           in_reg;
    logic signed [63:0] product_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [31:0] yd_reg, yd_next;
    logic signed [31:0] yf_reg, yf_next;
    logic signed [31:0] pred_reg, pred_next;
    logic signed [31:0] err_reg, err_next;
    out_item_t          out_reg, out_next;

    // Shared multiplier operands
    logic signed [31:0] mul_a, mul_b;
    logic               mul_en;

    logic               in_xfer, out_free;
    logic signed [31:0] term, meas, ref_val, u_sat, u_clamp;
    logic [63:0]        meas_wide, u_shift;
    logic signed [ACC_W-1:0] acc_sum;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    // Scale the held sample into fixed point
    assign meas_wide = 64'(in_reg.measured_temp) << (FRAC_BITS - 2);
    assign meas      = meas_wide[31:0];
    assign ref_val   = sat32(64'(in_reg.setpoint) <<< FRAC_BITS);
    assign term      = round_prod(product_reg);

    // Select multiplier operands for the current step
    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = (state_reg == ST_RUN);
        case (cnt_reg)
            STEP_D_NEW:
            begin
                mul_a = model_num0_reg;
                mul_b = hist_reg[DELAY-1];
            end
            STEP_D_OLD:
            begin
                mul_a = model_num1_reg;
                mul_b = hist_reg[DELAY];
            end
            STEP_D_FB:
            begin
                mul_a = model_den1_reg;
                mul_b = dprev_reg;
            end
            STEP_F_NEW:
            begin
                mul_a = model_num0_reg;
                mul_b = hist_reg[0];
            end
            STEP_F_OLD:
            begin
                mul_a = model_num1_reg;
                mul_b = hist_reg[0];
            end
            STEP_F_FB:
            begin
                mul_a = model_den1_reg;
                mul_b = fprev_reg;
            end
            STEP_P_PREV:
            begin
                mul_a = gain_prev_reg;
                mul_b = err_last_reg;
            end
            STEP_P_PREV2:
            begin
                mul_a = gain_prev2_reg;
                mul_b = err_before_reg;
            end
            STEP_P_NOW:
            begin
                mul_a = gain_now_reg;
                mul_b = err_reg;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Final control sum, clamp and duty
    assign acc_sum = acc_reg + ACC_W'(term);
    assign u_sat   = sat32(64'(acc_sum));
    always_comb
    begin
        if (u_sat > TOP_U)
            u_clamp = TOP_U;
        else if (u_sat < 32'sd0)
            u_clamp = 32'sd0;
        else
            u_clamp = u_sat;
    end
    assign u_shift = {32'b0, u_clamp} >> FRAC_BITS;

    // Sequencer and datapath next state
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        started_next    = started_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        acc_next        = acc_reg;
        yd_next         = yd_reg;
        yf_next         = yf_reg;
        pred_next       = pred_reg;
        err_next        = err_reg;
        err_last_next   = err_last_reg;
        err_before_next = err_before_reg;
        dprev_next      = dprev_reg;
        fprev_next      = fprev_reg;
        for (int i = 0; i < HIST_DEPTH; i++)
            hist_next[i] = hist_reg[i];

        // Drop the result once it is taken
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    cnt_next   = STEP_D_NEW;
                    state_next = started_reg ? ST_RUN : ST_PRIME;
                end
            end
            ST_PRIME:
            begin
                // Load both models with the first measurement
                if (out_free)
                begin
                    dprev_next                = meas;
                    fprev_next                = meas;
                    started_next              = 1'b1;
                    out_next.duty             = '0;
                    out_next.predicted_temp   = '0;
                    out_valid_next            = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            ST_RUN:
            begin
                // Accumulate the product issued in the previous step
                cnt_next = cnt_reg + STEP_W'(1);
                case (cnt_reg)
                    STEP_D_OLD:   acc_next = ACC_W'(term);
                    STEP_D_FB:    acc_next = acc_reg + ACC_W'(term);
                    STEP_F_NEW:
                    begin
                        acc_next = acc_reg - ACC_W'(term);
                        yd_next  = sat32(64'(acc_reg - ACC_W'(term)));
                    end
                    STEP_F_OLD:   acc_next = ACC_W'(term);
                    STEP_F_FB:    acc_next = acc_reg + ACC_W'(term);
                    STEP_P_PREV:
                    begin
                        acc_next = acc_reg - ACC_W'(term);
                        yf_next  = sat32(64'(acc_reg - ACC_W'(term)));
                    end
                    STEP_P_PREV2:
                    begin
                        acc_next  = ACC_W'(hist_reg[0]) + ACC_W'(term);
                        pred_next = sat32(64'(ACC_W'(yf_reg) + ACC_W'(meas)
                                              - ACC_W'(yd_reg)));
                    end
                    STEP_ERR:
                    begin
                        acc_next = acc_reg + ACC_W'(term);
                        err_next = sat32(64'(ACC_W'(ref_val) - ACC_W'(pred_reg)));
                    end
                    STEP_P_NOW:
                    begin
                        acc_next = acc_reg;
                    end
                    STEP_LAST:
                    begin
                        // Commit when the output register is free, else hold
                        cnt_next = cnt_reg;
                        if (out_free)
                        begin
                            err_before_next         = err_last_reg;
                            err_last_next           = err_reg;
                            dprev_next              = yd_reg;
                            fprev_next              = yf_reg;
                            for (int i = 1; i < HIST_DEPTH; i++)
                                hist_next[i] = hist_reg[i-1];
                            hist_next[0]            = u_clamp;
                            out_next.duty           = u_shift[9:0];
                            out_next.predicted_temp = pred_reg;
                            out_valid_next          = 1'b1;
                            state_next              = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        acc_next = acc_reg;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and controller state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= STEP_D_NEW;
            started_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            err_last_reg   <= '0;
            err_before_reg <= '0;
            dprev_reg      <= '0;
            fprev_reg      <= '0;
            for (int i = 0; i < HIST_DEPTH; i++)
                hist_reg[i] <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            started_reg    <= started_next;
            out_valid_reg  <= out_valid_next;
            err_last_reg   <= err_last_next;
            err_before_reg <= err_before_next;
            dprev_reg      <= dprev_next;
            fprev_reg      <= fprev_next;
            for (int i = 0; i < HIST_DEPTH; i++)
                hist_reg[i] <= hist_next[i];
        end
    end

    // Coefficient registers, written by configuration transfers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_now_reg   <= RST_GAIN_NOW;
            gain_prev_reg  <= RST_GAIN_PREV;
            gain_prev2_reg <= RST_GAIN_PREV2;
            model_num0_reg <= RST_MODEL_NUM0;
            model_num1_reg <= RST_MODEL_NUM1;
            model_den1_reg <= RST_MODEL_DEN1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GAIN_NOW:   gain_now_reg   <= cfg_data;
                CFG_GAIN_PREV:  gain_prev_reg  <= cfg_data;
                CFG_GAIN_PREV2: gain_prev2_reg <= cfg_data;
                CFG_MODEL_NUM0: model_num0_reg <= cfg_data;
                CFG_MODEL_NUM1: model_num1_reg <= cfg_data;
                CFG_MODEL_DEN1: model_den1_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Payload and work registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            in_reg <= in_data;
        if (mul_en)
            product_reg <= 64'(mul_a) * 64'(mul_b);
        acc_reg  <= acc_next;
        yd_reg   <= yd_next;
        yf_reg   <= yf_next;
        pred_reg <= pred_next;
        err_reg  <= err_next;
        out_reg  <= out_next;
    end

endmodule
